[hw/rtl/assert_macros.svh]
// Assertion macros shared by the node key table RTL.
// Clock and active-low reset are passed in by each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NKT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("node key table check failed");

// next-cycle implication
`define NKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("node key table check failed");

`endif

[hw/rtl/nkt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the node key table.
// Used by the controller, the datapath and the top level.
package nkt_pkg;

  localparam int ACT_W    = 3;
  localparam int ADDR_W   = 16;
  localparam int MAC_W    = 48;
  localparam int KEY_W    = 64;
  localparam int ELEM_W   = 8;
  localparam int SLOT_W   = 3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP_ADDR = 3'd0,
    ACT_LOOKUP_MAC  = 3'd1,
    ACT_ADD         = 3'd2,
    ACT_DELETE      = 3'd3,
    ACT_CLEAR       = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_RESOLVE,
    S_ACCESS,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [MAC_W-1:0]  mac;
    logic [KEY_W-1:0]  key_high;
    logic [KEY_W-1:0]  key_low;
    logic [ELEM_W-1:0] elements;
  } entry_row_t;

  typedef struct packed {
    logic load;
    logic match;
    logic resolve;
    logic access;
  } cmd_t;

  typedef struct packed {
    logic fast_path;
  } sts_t;

endpackage

[hw/rtl/nkt_ram.sv]
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module nkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/nkt_ctrl.sv]
`timescale 1ns / 1ps
// Request sequencer of the node key table.
// Depends on nkt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module nkt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  nkt_pkg::sts_t sts,
  output nkt_pkg::cmd_t cmd
);

  nkt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nkt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      nkt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = nkt_pkg::S_MATCH;
        end
      end
      nkt_pkg::S_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = sts.fast_path ? nkt_pkg::S_ACCESS : nkt_pkg::S_RESOLVE;
      end
      nkt_pkg::S_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_nxt   = nkt_pkg::S_ACCESS;
      end
      nkt_pkg::S_ACCESS: begin
        cmd.access = 1'b1;
        state_nxt  = nkt_pkg::S_RESULT;
      end
      nkt_pkg::S_RESULT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = nkt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = nkt_pkg::S_IDLE;
      end
    endcase
  end

  `NKT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall && !out_valid)
  `NKT_ASSERT_NOW(a_one_command, clk, rst_n, 1'b1, $onehot0(cmd))
  `NKT_ASSERT_NEXT(a_access_then_result, clk, rst_n, cmd.access, out_valid)

endmodule

[hw/rtl/nkt_datapath.sv]
`timescale 1ns / 1ps
// Address/MAC match cells, slot select and entry RAM of the node key table.
// Depends on nkt_pkg, nkt_ram and assert_macros.svh.
`include "assert_macros.svh"
module nkt_datapath #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nkt_pkg::cmd_t                cmd,
  output nkt_pkg::sts_t                sts,
  input  logic [nkt_pkg::ACT_W-1:0]    in_action,
  input  logic [nkt_pkg::ADDR_W-1:0]   in_node_addr,
  input  logic [nkt_pkg::MAC_W-1:0]    in_node_mac,
  input  logic [nkt_pkg::KEY_W-1:0]    in_key_high,
  input  logic [nkt_pkg::KEY_W-1:0]    in_key_low,
  input  logic [nkt_pkg::ELEM_W-1:0]   in_element_count,
  output logic                         out_status,
  output logic [nkt_pkg::SLOT_W-1:0]   out_slot,
  output logic [nkt_pkg::ADDR_W-1:0]   out_found_addr,
  output logic [nkt_pkg::MAC_W-1:0]    out_found_mac,
  output logic [nkt_pkg::KEY_W-1:0]    out_found_key_high,
  output logic [nkt_pkg::KEY_W-1:0]    out_found_key_low,
  output logic [nkt_pkg::ELEM_W-1:0]   out_found_elements
);

  logic [nkt_pkg::ACT_W-1:0]  req_action_r;
  logic [nkt_pkg::ADDR_W-1:0] req_addr_r;
  logic [nkt_pkg::MAC_W-1:0]  req_mac_r;
  logic [nkt_pkg::KEY_W-1:0]  req_key_high_r;
  logic [nkt_pkg::KEY_W-1:0]  req_key_low_r;
  logic [nkt_pkg::ELEM_W-1:0] req_elem_r;

  logic [nkt_pkg::ADDR_W-1:0] addr_r [DEPTH];
  logic [nkt_pkg::MAC_W-1:0]  mac_r  [DEPTH];

  logic [DEPTH-1:0] used;
  logic [DEPTH-1:0] addr_hit_nxt, mac_hit_nxt;
  logic [DEPTH-1:0] addr_hit_r, mac_hit_r, free_r;
  logic [DEPTH-1:0] pick_vec;
  logic [IDX_W-1:0] pick_idx;
  logic [IDX_W-1:0] sel_idx_r;
  logic             sel_hit_r;
  logic [31:0]      sel_wide;

  logic                       res_status_r;
  logic [nkt_pkg::SLOT_W-1:0] res_slot_r;
  logic                       res_ram_r;
  logic                       res_req_r;

  logic                  ram_we, ram_re;
  nkt_pkg::entry_row_t   req_row, rd_row, out_row;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action_r   <= in_action;
      req_addr_r     <= in_node_addr;
      req_mac_r      <= in_node_mac;
      req_key_high_r <= in_key_high;
      req_key_low_r  <= in_key_low;
      req_elem_r     <= in_element_count;
    end
  end

  always_comb begin
    unique case (req_action_r) inside
      nkt_pkg::ACT_LOOKUP_ADDR, nkt_pkg::ACT_LOOKUP_MAC,
      nkt_pkg::ACT_ADD, nkt_pkg::ACT_DELETE: sts.fast_path = 1'b0;
      default:                                sts.fast_path = 1'b1;
    endcase
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      used[i]         = addr_r[i] != '0;
      addr_hit_nxt[i] = (req_addr_r != '0) && (addr_r[i] == req_addr_r);
      mac_hit_nxt[i]  = used[i] && (mac_r[i] == req_mac_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      addr_hit_r <= addr_hit_nxt;
      mac_hit_r  <= mac_hit_nxt;
      free_r     <= ~used;
    end
  end

  always_comb begin
    unique case (req_action_r) inside
      nkt_pkg::ACT_LOOKUP_ADDR, nkt_pkg::ACT_DELETE: pick_vec = addr_hit_r;
      nkt_pkg::ACT_LOOKUP_MAC:                         pick_vec = mac_hit_r;
      nkt_pkg::ACT_ADD: begin
        if (req_addr_r == '0) begin
          pick_vec = '0;
        end else if (|addr_hit_r) begin
          pick_vec = addr_hit_r;
        end else begin
          pick_vec = free_r;
        end
      end
      default: pick_vec = '0;
    endcase
  end

  always_comb begin
    pick_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (pick_vec[i]) begin
        pick_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      sel_idx_r <= pick_idx;
      sel_hit_r <= |pick_vec;
    end
  end

  assign sel_wide = 32'(sel_idx_r);

  always_comb begin
    ram_we = 1'b0;
    ram_re = 1'b0;
    case (req_action_r) inside
      nkt_pkg::ACT_ADD: ram_we = cmd.access && sel_hit_r;
      nkt_pkg::ACT_LOOKUP_ADDR, nkt_pkg::ACT_LOOKUP_MAC, nkt_pkg::ACT_DELETE:
        ram_re = cmd.access && sel_hit_r;
      default: begin
        ram_we = 1'b0;
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        addr_r[i] <= '0;
      end
    end else if (cmd.access) begin
      case (req_action_r) inside
        nkt_pkg::ACT_ADD: begin
          if (sel_hit_r) begin
            addr_r[sel_idx_r] <= req_addr_r;
          end
        end
        nkt_pkg::ACT_DELETE: begin
          if (sel_hit_r) begin
            addr_r[sel_idx_r] <= '0;
          end
        end
        nkt_pkg::ACT_CLEAR: begin
          for (int i = 0; i < DEPTH; i++) begin
            addr_r[i] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.access && (req_action_r == nkt_pkg::ACT_ADD) && sel_hit_r) begin
      mac_r[sel_idx_r] <= req_mac_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_status_r <= nkt_pkg::STATUS_MISS;
      res_slot_r   <= '0;
      res_ram_r    <= 1'b0;
      res_req_r    <= 1'b0;
    end else if (cmd.access) begin
      case (req_action_r) inside
        nkt_pkg::ACT_LOOKUP_ADDR, nkt_pkg::ACT_LOOKUP_MAC, nkt_pkg::ACT_DELETE: begin
          res_status_r <= sel_hit_r ? nkt_pkg::STATUS_OK : nkt_pkg::STATUS_MISS;
          res_slot_r   <= sel_hit_r ? sel_wide[nkt_pkg::SLOT_W-1:0] : '0;
          res_ram_r    <= sel_hit_r;
          res_req_r    <= 1'b0;
        end
        nkt_pkg::ACT_ADD: begin
          res_status_r <= sel_hit_r ? nkt_pkg::STATUS_OK : nkt_pkg::STATUS_MISS;
          res_slot_r   <= sel_hit_r ? sel_wide[nkt_pkg::SLOT_W-1:0] : '0;
          res_ram_r    <= 1'b0;
          res_req_r    <= sel_hit_r;
        end
        nkt_pkg::ACT_CLEAR: begin
          res_status_r <= nkt_pkg::STATUS_OK;
          res_slot_r   <= '0;
          res_ram_r    <= 1'b0;
          res_req_r    <= 1'b0;
        end
        default: begin
          res_status_r <= nkt_pkg::STATUS_MISS;
          res_slot_r   <= '0;
          res_ram_r    <= 1'b0;
          res_req_r    <= 1'b0;
        end
      endcase
    end
  end

  assign req_row = '{addr:     req_addr_r,
                     mac:      req_mac_r,
                     key_high: req_key_high_r,
                     key_low:  req_key_low_r,
                     elements: req_elem_r};

  nkt_ram #(
    .WIDTH ($bits(nkt_pkg::entry_row_t)),
    .DEPTH (DEPTH),
    .AW    (IDX_W)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (sel_idx_r),
    .wdata (req_row),
    .rdata (rd_row)
  );

  assign out_row = res_ram_r ? rd_row : (res_req_r ? req_row : '0);

  assign out_status         = res_status_r;
  assign out_slot           = res_slot_r;
  assign out_found_addr     = out_row.addr;
  assign out_found_mac      = out_row.mac;
  assign out_found_key_high = out_row.key_high;
  assign out_found_key_low  = out_row.key_low;
  assign out_found_elements = out_row.elements;

  `NKT_ASSERT_NEXT(a_clear_empties, clk, rst_n, cmd.access && (req_action_r == nkt_pkg::ACT_CLEAR), used == '0)
  `NKT_ASSERT_NOW(a_one_source, clk, rst_n, 1'b1, !(res_ram_r && res_req_r))
  `NKT_ASSERT_NEXT(a_add_marks_used, clk, rst_n, ram_we, used[sel_idx_r])

endmodule

[hw/rtl/node_key_table.sv]
`timescale 1ns / 1ps
// Node key table: address/MAC searchable table of mesh node entries.
// Each request runs match, slot select (skipped for clear and unknown codes),
// entry RAM access and result one after another; the result is held while
// out_stall is high, and no new request is accepted until it is taken.
// Reset (synchronous, rst_n low) empties the table; no clearing pass needed.
module node_key_table #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [nkt_pkg::ACT_W-1:0]   in_action,
  input  logic [nkt_pkg::ADDR_W-1:0]  in_node_addr,
  input  logic [nkt_pkg::MAC_W-1:0]   in_node_mac,
  input  logic [nkt_pkg::KEY_W-1:0]   in_key_high,
  input  logic [nkt_pkg::KEY_W-1:0]   in_key_low,
  input  logic [nkt_pkg::ELEM_W-1:0]  in_element_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_status,
  output logic [nkt_pkg::SLOT_W-1:0]  out_slot,
  output logic [nkt_pkg::ADDR_W-1:0]  out_found_addr,
  output logic [nkt_pkg::MAC_W-1:0]   out_found_mac,
  output logic [nkt_pkg::KEY_W-1:0]   out_found_key_high,
  output logic [nkt_pkg::KEY_W-1:0]   out_found_key_low,
  output logic [nkt_pkg::ELEM_W-1:0]  out_found_elements
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  nkt_pkg::cmd_t cmd;
  nkt_pkg::sts_t sts;

  nkt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  nkt_datapath #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_action),
    .in_node_addr       (in_node_addr),
    .in_node_mac        (in_node_mac),
    .in_key_high        (in_key_high),
    .in_key_low         (in_key_low),
    .in_element_count   (in_element_count),
    .out_status         (out_status),
    .out_slot           (out_slot),
    .out_found_addr     (out_found_addr),
    .out_found_mac      (out_found_mac),
    .out_found_key_high (out_found_key_high),
    .out_found_key_low  (out_found_key_low),
    .out_found_elements (out_found_elements)
  );

endmodule
